// ----- design/bounded_stack_with_key_search_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bounded stack with key search unit
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_STACK_WITH_KEY_SEARCH_UNIT_MACROS_SVH
`define BOUNDED_STACK_WITH_KEY_SEARCH_UNIT_MACROS_SVH

`ifndef SYNTH
// Checks a property on every rising clock edge outside reset.
`define BSKS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bsks assertion failed");
// Checks that a condition holds in the cycle after a trigger.
`define BSKS_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error("bsks next-cycle assertion failed");
`else
`define BSKS_ASSERT(lbl, prop)
`define BSKS_ASSERT_NEXT(lbl, trig, cond)
`endif

`endif

// ----- design/bsks_pkg.sv -----
// ----------------------------------------------------------------------------
// bsks_pkg
// Shared types and constants of the bounded stack with key search unit.
// ----------------------------------------------------------------------------
package bsks_pkg;

  localparam int unsigned DEFAULT_DEPTH = 8;
  localparam int unsigned KEY_W         = 32;
  localparam int unsigned PAGES_W       = 16;
  localparam int unsigned POS_W         = 3;
  localparam int unsigned REQ_W         = 3;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned REC_W         = KEY_W + PAGES_W;

  // Request codes. Code 7 is unused and behaves as a status request.
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_PEEK   = 3'd2,
    REQ_SEARCH = 3'd3,
    REQ_DUMP   = 3'd4,
    REQ_CLEAR  = 3'd5,
    REQ_STATUS = 3'd6
  } req_type_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [REQ_W-1:0]          req_type;
    logic signed [KEY_W-1:0]   key;
    logic [PAGES_W-1:0]        pages;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [POS_W-1:0]          position;
    logic signed [KEY_W-1:0]   rec_key;
    logic [PAGES_W-1:0]        rec_pages;
    logic                      is_empty;
    logic                      is_full;
    logic                      last;
  } res_t;

  // Source of the next pending result record.
  typedef enum logic [2:0] {
    PEND_HOLD,
    PEND_ERR_FULL,
    PEND_ERR_EMPTY,
    PEND_NOT_FOUND,
    PEND_ZERO,
    PEND_PUSH,
    PEND_RAM
  } pend_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WAIT_TOP,
    S_WALK,
    S_FINAL
  } ctl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      accept;
    logic      push_write;
    logic      fill_dec;
    logic      fill_clr;
    logic      rd_top;
    logic      rd_next;
    pend_sel_e pend_sel;
    logic      emit;
    logic      emit_last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             empty;
    logic             full;
    logic             key_match;
    logic             pend_vld;
    logic             ptr_zero;
  } dp_stat_t;

endpackage

// ----- design/bsks_ram.sv -----
// ----------------------------------------------------------------------------
// bsks_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsks_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/bsks_ctrl.sv -----
// ----------------------------------------------------------------------------
// bsks_ctrl
// Request sequencer: decodes a request and steers the stack datapath.
// ----------------------------------------------------------------------------
module bsks_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  bsks_pkg::dp_stat_t stat_i,
  output bsks_pkg::dp_cmd_t  cmd_o,
  output logic               busy_o
);

  import bsks_pkg::*;

  ctl_state_e state_q, state_d;
  logic       hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // During the walk a dump takes every entry, a search only matching keys.
  assign hit = (stat_i.req_type == REQ_DUMP) || stat_i.key_match;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_FINAL;
        case (stat_i.req_type)
          REQ_PUSH: begin
            if (stat_i.full) begin
              cmd_o.pend_sel = PEND_ERR_FULL;
            end else begin
              cmd_o.push_write = 1'b1;
              cmd_o.pend_sel   = PEND_PUSH;
            end
          end
          REQ_POP, REQ_PEEK: begin
            if (stat_i.empty) begin
              cmd_o.pend_sel = PEND_ERR_EMPTY;
            end else begin
              cmd_o.rd_top   = 1'b1;
              cmd_o.fill_dec = (stat_i.req_type == REQ_POP);
              state_d        = S_WAIT_TOP;
            end
          end
          REQ_SEARCH, REQ_DUMP: begin
            if (stat_i.empty) begin
              cmd_o.pend_sel = PEND_ERR_EMPTY;
            end else begin
              cmd_o.rd_top = 1'b1;
              state_d      = S_WALK;
            end
          end
          REQ_CLEAR: begin
            cmd_o.fill_clr = 1'b1;
            cmd_o.pend_sel = PEND_ZERO;
          end
          default: begin
            cmd_o.pend_sel = PEND_ZERO;
          end
        endcase
      end
      S_WAIT_TOP: begin
        cmd_o.pend_sel = PEND_RAM;
        state_d        = S_FINAL;
      end
      S_WALK: begin
        // A new hit pushes the previously held hit out as a non-final beat.
        if (hit) begin
          cmd_o.pend_sel = PEND_RAM;
          cmd_o.emit     = stat_i.pend_vld;
        end
        if (stat_i.ptr_zero) begin
          if (!hit && !stat_i.pend_vld) begin
            cmd_o.pend_sel = PEND_NOT_FOUND;
          end
          state_d = S_FINAL;
        end else begin
          cmd_o.rd_next = 1'b1;
        end
      end
      S_FINAL: begin
        cmd_o.emit_last = 1'b1;
        state_d         = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ----- design/bsks_dp.sv -----
// ----------------------------------------------------------------------------
// bsks_dp
// Stack datapath: record storage, fill count, walk pointer and result register.
// ----------------------------------------------------------------------------
module bsks_dp #(
  parameter int unsigned DEPTH = bsks_pkg::DEFAULT_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bsks_pkg::req_t     req_i,
  input  bsks_pkg::dp_cmd_t  cmd_i,
  output bsks_pkg::dp_stat_t stat_o,
  output bsks_pkg::res_t     res_o,
  output logic               strobe_o
);

  import bsks_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [POS_W-1:0]        position;
    logic signed [KEY_W-1:0] rec_key;
    logic [PAGES_W-1:0]      rec_pages;
  } pend_t;

  req_t              req_q;
  logic [CW-1:0]     fill_q, fill_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  pend_t             pend_q, pend_d;
  logic              pend_vld_q, pend_vld_d;
  res_t              res_q, res_d;
  logic              strobe_q;

  logic [CW-1:0]     top_c;
  logic [AW-1:0]     ptr_m1;
  logic [AW-1:0]     raddr;
  logic [REC_W-1:0]  rdata;
  logic [AW+2:0]     fill_ext;
  logic [AW+2:0]     ptr_ext;
  logic              empty;
  logic              full;

  assign top_c    = fill_q - CW'(1);
  assign ptr_m1   = ptr_q - AW'(1);
  assign raddr    = cmd_i.rd_top ? top_c[AW-1:0] : ptr_m1;
  assign empty    = (fill_q == '0);
  assign full     = (fill_q == CW'(DEPTH));
  // The reported position is the low bits of the slot number.
  assign fill_ext = {3'b000, fill_q[AW-1:0]};
  assign ptr_ext  = {3'b000, ptr_q};

  bsks_ram #(
    .WIDTH (REC_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push_write),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i ({req_q.key, req_q.pages}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.fill_clr) begin
      fill_d = '0;
    end else if (cmd_i.push_write) begin
      fill_d = fill_q + CW'(1);
    end else if (cmd_i.fill_dec) begin
      fill_d = top_c;
    end

    ptr_d = ptr_q;
    if (cmd_i.rd_top) begin
      ptr_d = top_c[AW-1:0];
    end else if (cmd_i.rd_next) begin
      ptr_d = ptr_m1;
    end

    pend_d     = pend_q;
    pend_vld_d = cmd_i.accept ? 1'b0 : pend_vld_q;
    case (cmd_i.pend_sel)
      PEND_HOLD: begin
        pend_d = pend_q;
      end
      PEND_ERR_FULL: begin
        pend_d = '{STAT_FULL, '0, '0, '0};
      end
      PEND_ERR_EMPTY: begin
        pend_d = '{STAT_EMPTY, '0, '0, '0};
      end
      PEND_NOT_FOUND: begin
        pend_d = '{STAT_NOT_FOUND, '0, req_q.key, '0};
      end
      PEND_ZERO: begin
        pend_d = '{STAT_OK, '0, '0, '0};
      end
      PEND_PUSH: begin
        pend_d = '{STAT_OK, fill_ext[POS_W-1:0], req_q.key, req_q.pages};
      end
      PEND_RAM: begin
        pend_d = '{STAT_OK, ptr_ext[POS_W-1:0], rdata[REC_W-1:PAGES_W],
                   rdata[PAGES_W-1:0]};
        pend_vld_d = 1'b1;
      end
      default: begin
        pend_d = pend_q;
      end
    endcase

    res_d = '{pend_q.status, pend_q.position, pend_q.rec_key, pend_q.rec_pages,
              empty, full, cmd_i.emit_last};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      ptr_q      <= '0;
      pend_vld_q <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      ptr_q      <= ptr_d;
      pend_vld_q <= pend_vld_d;
      strobe_q   <= cmd_i.emit || cmd_i.emit_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= req_i;
    end
    pend_q <= pend_d;
    if (cmd_i.emit || cmd_i.emit_last) begin
      res_q <= res_d;
    end
  end

  assign stat_o = '{req_q.req_type, empty, full,
                    (rdata[REC_W-1:PAGES_W] == req_q.key), pend_vld_q,
                    (ptr_q == '0)};
  assign res_o    = res_q;
  assign strobe_o = strobe_q;

endmodule

// ----- design/bounded_stack_with_key_search_unit.sv -----
// ----------------------------------------------------------------------------
// bounded_stack_with_key_search_unit
// Bounded LIFO stack of key and page-count records with search and dump.
// ----------------------------------------------------------------------------
// Usage: a request beat (push, pop, peek, search, dump, clear, status) is taken
// at a rising edge where start is high and busy is low. Results leave on res_o,
// each shown for exactly one cycle while strobe_o is high; the receiver must
// take every beat as it comes, since it cannot stall the unit. The final result
// of a request has last set, and every result carries the empty and full flags
// as they stand after the request.
// Timing: push, clear and status go from decode straight to the final state and
// give their single result; pop and peek also pass through S_WAIT_TOP for the
// registered read of the record memory. Search and dump walk the stored records
// from the top down one per cycle through the memory's read port; one result per
// match (or one not-found beat) comes out.
// busy drops in the cycle the final result is shown, so the next request can be
// taken at the end of that cycle.
// Reset empties the stack at once; the record memory itself is not cleared, as
// only slots below the fill count are ever read.
// ----------------------------------------------------------------------------
`include "bounded_stack_with_key_search_unit_macros.svh"

module bounded_stack_with_key_search_unit #(
  parameter int unsigned DEPTH = bsks_pkg::DEFAULT_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  bsks_pkg::req_t req_i,
  output logic           busy,
  output bsks_pkg::res_t res_o,
  output logic           strobe_o
);

  import bsks_pkg::*;

  // Command and status bundles between the sequencer and the datapath.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The sequencer owns the request flow: it accepts a beat, decodes it against
  // the current fill state and steps the datapath through the walk.
  bsks_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // The datapath holds the records, the fill count, the walk pointer, one
  // pending result (so that the final hit of a walk can be marked last) and
  // the output register.
  bsks_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .res_o    (res_o),
    .strobe_o (strobe_o)
  );

  // An accepted request always keeps the unit busy in the next cycle.
  `BSKS_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)
  // The final beat of a request coincides with the unit becoming free.
  `BSKS_ASSERT(a_last_when_free, (strobe_o && res_o.last) |-> !busy)
  // Beats before the final one only appear while the walk is still running.
  `BSKS_ASSERT(a_more_while_busy, (strobe_o && !res_o.last) |-> busy)
  // Error outcomes are always the one and only beat of their request.
  `BSKS_ASSERT(a_error_is_last, (strobe_o && (res_o.status == STAT_FULL ||
    res_o.status == STAT_EMPTY || res_o.status == STAT_NOT_FOUND)) |-> res_o.last)

endmodule
